// ===== rtl/rwsc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwsc_pkg
// Shared types, codes and helpers for the Reno window sender control block.
// ----------------------------------------------------------------------------
package rwsc_pkg;

    // widths of the sequence space, congestion window, duplicate count, timer and config port
    localparam int SEQ_BITS  = 16;
    localparam int CWND_BITS = 10;
    localparam int DUP_BITS  = 3;
    localparam int TMR_BITS  = 32;
    localparam int CFG_IDX_BITS = 2;
    localparam int CFG_DATA_BITS = 32;

    localparam logic [CWND_BITS-1:0] CWND_MAX = {CWND_BITS{1'b1}};
    localparam logic [DUP_BITS-1:0]  DUP_LIMIT = DUP_BITS'(3);
    localparam logic [DUP_BITS-1:0]  DUP_MAX   = {DUP_BITS{1'b1}};
    localparam logic [TMR_BITS-1:0]  TMR_MAX   = {TMR_BITS{1'b1}};
    localparam logic [CWND_BITS-1:0] FAST_RTX_EXTRA = CWND_BITS'(3);

    // reset values of the registers
    localparam logic [CWND_BITS-1:0] RST_WIN_LIMIT    = CWND_BITS'(10);
    localparam logic [CWND_BITS-1:0] RST_INIT_THRESH  = CWND_BITS'(16);
    localparam logic [TMR_BITS-1:0]  RST_TIMEOUT      = TMR_BITS'(5000);

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_WIN_LIMIT    = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_INIT_THRESH  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TIMEOUT      = 2'd2;

    // command codes
    localparam logic [1:0] CMD_SEND = 2'd0;
    localparam logic [1:0] CMD_ACK  = 2'd1;
    localparam logic [1:0] CMD_TICK = 2'd2;

    // resend kinds
    localparam logic [1:0] RESEND_NONE   = 2'd0;
    localparam logic [1:0] RESEND_OLDEST = 2'd1;
    localparam logic [1:0] RESEND_ALL    = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_ACK  = 2'd1;
    localparam logic [1:0] ST_REFUSED  = 2'd2;

    typedef enum logic [1:0] {
        PH_SLOW  = 2'd0,
        PH_AVOID = 2'd1,
        PH_RECOV = 2'd2
    } t_phase;

    typedef struct packed {
        logic [1:0]          command;
        logic [SEQ_BITS-1:0] ack_seq;
        logic                ack_valid;
    } t_in_item;

    typedef struct packed {
        logic                 send_granted;
        logic [SEQ_BITS-1:0]  send_seq;
        logic [1:0]           resend_kind;
        logic [SEQ_BITS-1:0]  resend_from;
        logic [CWND_BITS-1:0] resend_count;
        logic [CWND_BITS-1:0] released_count;
        logic [CWND_BITS-1:0] window_now;
        logic [CWND_BITS-1:0] threshold_now;
        logic [1:0]           phase_now;
        logic [SEQ_BITS-1:0]  base_now;
        logic [1:0]           status;
    } t_out_item;

    // live configuration seen by the core
    typedef struct packed {
        logic [CWND_BITS-1:0] win_limit;
        logic [TMR_BITS-1:0]  timeout_ticks;
    } t_cfg;

    // window grows by one, saturating
    function automatic logic [CWND_BITS-1:0] cwnd_inc(input logic [CWND_BITS-1:0] w);
        return (w == CWND_MAX) ? w : w + CWND_BITS'(1);
    endfunction

    // window never drops below one
    function automatic logic [CWND_BITS-1:0] cwnd_clamp(input logic [CWND_BITS-1:0] w);
        return (w == '0) ? CWND_BITS'(1) : w;
    endfunction

endpackage

// ===== rtl/rwsc_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwsc_cfg_regs
// Configuration register file: decodes writes to the window cap and timeout.
// ----------------------------------------------------------------------------
module rwsc_cfg_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [rwsc_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  logic [rwsc_pkg::CFG_DATA_BITS-1:0]  i_cfg_wdata,
    output rwsc_pkg::t_cfg                      o_cfg
);
    import rwsc_pkg::*;

    logic [CWND_BITS-1:0] r_win_limit;
    logic [TMR_BITS-1:0]  r_timeout;

    // register writes; the initial threshold only matters at reset, and reset
    // also restores it, so a write to it has no lasting effect
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_limit <= RST_WIN_LIMIT;
            r_timeout   <= RST_TIMEOUT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_WIN_LIMIT: r_win_limit <= i_cfg_wdata[CWND_BITS-1:0];
                CFG_TIMEOUT:   r_timeout   <= i_cfg_wdata[TMR_BITS-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg.win_limit     = r_win_limit;
    assign o_cfg.timeout_ticks = r_timeout;

endmodule

// ===== rtl/rwsc_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwsc_core
// Sender state and per-event update: grants, ack handling, Reno window
// control and the retransmit timer.
// ----------------------------------------------------------------------------
module rwsc_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  rwsc_pkg::t_in_item  i_item,
    input  rwsc_pkg::t_cfg      i_cfg,
    output rwsc_pkg::t_out_item o_result
);
    import rwsc_pkg::*;

    logic [CWND_BITS-1:0] r_cwnd,  n_cwnd;
    logic [CWND_BITS-1:0] r_ssth,  n_ssth;
    t_phase               r_phase, n_phase;
    logic [SEQ_BITS-1:0]  r_base,  n_base;
    logic [SEQ_BITS-1:0]  r_next,  n_next;
    logic [DUP_BITS-1:0]  r_dup,   n_dup;
    logic [CWND_BITS-1:0] r_step,  n_step;
    logic [TMR_BITS-1:0]  r_timer, n_timer;

    logic [SEQ_BITS-1:0]  outstanding;
    logic [SEQ_BITS-1:0]  offset;
    logic [SEQ_BITS-1:0]  ack_next;
    logic [CWND_BITS-1:0] cwnd_up;
    logic [CWND_BITS-1:0] half_cwnd;
    logic [CWND_BITS-1:0] step_up;
    logic [DUP_BITS-1:0]  dup_up;
    logic [TMR_BITS-1:0]  timer_up;
    t_out_item            res;

    // shared distances and saturating increments
    always_comb begin
        outstanding = r_next - r_base;
        offset      = i_item.ack_seq - r_base;
        ack_next    = i_item.ack_seq + SEQ_BITS'(1);
        cwnd_up     = cwnd_inc(r_cwnd);
        half_cwnd   = r_cwnd >> 1;
        step_up     = (r_step == CWND_MAX) ? r_step : r_step + CWND_BITS'(1);
        dup_up      = (r_dup == DUP_MAX) ? r_dup : r_dup + DUP_BITS'(1);
        timer_up    = (r_timer == TMR_MAX) ? r_timer : r_timer + TMR_BITS'(1);
    end

    // next state and result for one event
    always_comb begin
        n_cwnd  = r_cwnd;
        n_ssth  = r_ssth;
        n_phase = r_phase;
        n_base  = r_base;
        n_next  = r_next;
        n_dup   = r_dup;
        n_step  = r_step;
        n_timer = r_timer;
        res     = '0;

        unique case (i_item.command)
            CMD_SEND: begin
                if ((outstanding < SEQ_BITS'(r_cwnd)) &&
                    (outstanding < SEQ_BITS'(i_cfg.win_limit))) begin
                    res.send_granted = 1'b1;
                    res.send_seq     = r_next;
                    if (outstanding == '0) begin
                        n_timer = '0;
                    end
                    n_next = r_next + SEQ_BITS'(1);
                end else begin
                    res.status = ST_REFUSED;
                end
            end
            CMD_ACK: begin
                if (!i_item.ack_valid) begin
                    res.status = ST_BAD_ACK;
                end else if (offset < outstanding) begin
                    // new ack: grow the window by phase, or leave recovery at the threshold
                    unique case (r_phase)
                        PH_SLOW: begin
                            n_cwnd = cwnd_up;
                            if (cwnd_up >= r_ssth) begin
                                n_phase = PH_AVOID;
                            end
                        end
                        PH_AVOID: begin
                            n_step = step_up;
                            if (step_up >= r_cwnd) begin
                                n_step = '0;
                                n_cwnd = cwnd_up;
                            end
                        end
                        default: begin
                            n_cwnd  = cwnd_clamp(r_ssth);
                            n_phase = PH_AVOID;
                            n_step  = '0;
                        end
                    endcase
                    res.released_count = offset[CWND_BITS-1:0] + CWND_BITS'(1);
                    n_base = ack_next;
                    n_dup  = '0;
                    if (ack_next != r_next) begin
                        n_timer = '0;
                    end
                end else begin
                    // duplicate ack
                    if (r_phase == PH_RECOV) begin
                        n_cwnd = cwnd_up;
                    end
                    n_dup = dup_up;
                    if (dup_up == DUP_LIMIT) begin
                        if (r_phase != PH_RECOV) begin
                            n_phase = PH_RECOV;
                            n_ssth  = half_cwnd;
                            n_cwnd  = cwnd_clamp(half_cwnd + FAST_RTX_EXTRA);
                        end
                        if (outstanding != '0) begin
                            res.resend_kind  = RESEND_OLDEST;
                            res.resend_from  = r_base;
                            res.resend_count = CWND_BITS'(1);
                        end
                    end
                end
            end
            CMD_TICK: begin
                if (outstanding != '0) begin
                    n_timer = timer_up;
                    if (timer_up >= i_cfg.timeout_ticks) begin
                        n_dup   = '0;
                        n_ssth  = half_cwnd;
                        n_cwnd  = CWND_BITS'(1);
                        n_phase = PH_SLOW;
                        n_timer = '0;
                        res.resend_kind  = RESEND_ALL;
                        res.resend_from  = r_base;
                        res.resend_count = outstanding[CWND_BITS-1:0];
                    end
                end
            end
            default: ;
        endcase

        res.window_now    = n_cwnd;
        res.threshold_now = n_ssth;
        res.phase_now     = n_phase;
        res.base_now      = n_base;
    end

    // state registers, updated once per processed event
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cwnd  <= CWND_BITS'(1);
            r_ssth  <= RST_INIT_THRESH;
            r_phase <= PH_SLOW;
            r_base  <= '0;
            r_next  <= '0;
            r_dup   <= '0;
            r_step  <= '0;
            r_timer <= '0;
        end else if (i_fire) begin
            r_cwnd  <= n_cwnd;
            r_ssth  <= n_ssth;
            r_phase <= n_phase;
            r_base  <= n_base;
            r_next  <= n_next;
            r_dup   <= n_dup;
            r_step  <= n_step;
            r_timer <= n_timer;
        end
    end

    assign o_result = res;

endmodule

// ===== rtl/reno_window_sender_control_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// reno_window_sender_control_top
// Go-back-N sender control with Reno congestion control: input register,
// single-pass event update, result register.
// ----------------------------------------------------------------------------
// flow: an accepted event loads the input register, then the result register
//   loads from it once the result stage is free
// throughput: one event per cycle; the state update is one pass of logic
//   between the input register and the result register; a stalled result
//   holds the input stage and drops the input ready only when both are full
// reset: synchronous active low; window 1, threshold 16, slow start, base and
//   next sequence 0, registers back to their reset values, both stages empty
module reno_window_sender_control_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  rwsc_pkg::t_in_item                  i_in_item,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output rwsc_pkg::t_out_item                 o_out_item,
    input  logic                                i_cfg_we,
    input  logic [rwsc_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  logic [rwsc_pkg::CFG_DATA_BITS-1:0]  i_cfg_wdata
);
    import rwsc_pkg::*;

    t_cfg      cfg;
    t_out_item result;
    logic      r_s1_valid;
    t_in_item  r_s1_item;
    logic      r_out_valid;
    t_out_item r_out_item;
    logic      out_free;
    logic      s1_fire;

    rwsc_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    rwsc_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (s1_fire),
        .i_item   (r_s1_item),
        .i_cfg    (cfg),
        .o_result (result)
    );

    // pipeline flow control
    assign out_free   = !r_out_valid || i_out_ready;
    assign s1_fire    = r_s1_valid && out_free;
    assign o_in_ready = !r_s1_valid || out_free;

    // input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_s1_item <= i_in_item;
        end
    end

    // result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_out_item <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

// ===== rtl/rwsc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwsc_checker
// Port-level checks for the Reno window sender control block.
// ----------------------------------------------------------------------------
module rwsc_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input rwsc_pkg::t_out_item o_out_item
);
    import rwsc_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("result changed while stalled");

    // reset empties the result stage
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // a granted send always reports ok
    a_grant_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.send_granted |-> o_out_item.status == ST_OK)
        else $error("granted send with bad status");

    // window never collapses to zero
    a_cwnd_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_item.window_now != '0)
        else $error("congestion window is zero");

    // a result with no resend kind carries no range
    a_no_resend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.resend_kind == RESEND_NONE |->
            o_out_item.resend_count == '0 && o_out_item.resend_from == '0)
        else $error("resend range without resend kind");

endmodule

bind reno_window_sender_control_top rwsc_checker u_rwsc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);

// ===== tb/reno_window_sender_control_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// reno_window_sender_control_top_test
// Self-checking bench for the Reno window sender control. Send requests,
// acknowledgements and timer ticks go in over a valid/ready channel. An
// in-bench copy of the sender state (window, threshold, phase, base, next
// sequence, duplicate count, timer) predicts every result, and each returned
// result is compared field by field in order. Phases cover several register
// settings and a duplicate-ACK storm up to the window ceiling, with random
// gaps on both sides outside the storm.
// ----------------------------------------------------------------------------
module reno_window_sender_control_top_test;
    import rwsc_pkg::*;

    localparam int          STALL_LIMIT   = 2000;  // cycles with no transfer
    localparam int          SETTLE_CYCLES = 4;     // idle wait after the last result is back
    localparam logic [1:0]  CMD_UNUSED    = 2'd3;
    localparam logic [2:0]  DUP_RTX       = 3'd3;

    // predicted sender state and the results still owed by the block
    class sender_window_board;
        logic [9:0]  win_cap;
        logic [9:0]  thresh_init;
        logic [31:0] expiry_ticks;
        logic [9:0]  cwnd;
        logic [9:0]  ssthresh;
        t_phase      ph;
        logic [15:0] base;
        logic [15:0] next_seq;
        logic [2:0]  dup_acks;
        logic [9:0]  avoid_acks;
        logic [31:0] rto_ticks;
        int          seen;
        int          mismatches;
        t_out_item   owed[$];

        function void restart();
            win_cap      = 10'd10;
            thresh_init  = 10'd16;
            expiry_ticks = 32'd5000;
            cwnd         = 10'd1;
            ssthresh     = thresh_init;
            ph           = PH_SLOW;
            base         = '0;
            next_seq     = '0;
            dup_acks     = '0;
            avoid_acks   = '0;
            rto_ticks    = '0;
            seen         = 0;
            mismatches   = 0;
        endfunction

        // saturating window growth
        function logic [9:0] grow(logic [9:0] w);
            return (w == '1) ? w : w + 10'd1;
        endfunction

        // window floor of one
        function logic [9:0] floor_one(logic [9:0] w);
            return (w == '0) ? 10'd1 : w;
        endfunction

        function logic [15:0] in_flight();
            return next_seq - base;
        endfunction

        function int pending();
            return owed.size();
        endfunction

        // the threshold register only matters at reset
        function void write_reg(logic [1:0] idx, logic [31:0] data);
            case (idx)
                CFG_WIN_LIMIT:   win_cap = data[9:0];
                CFG_INIT_THRESH: thresh_init = data[9:0];
                CFG_TIMEOUT:     expiry_ticks = data;
                default: ;
            endcase
        endfunction

        // advance the state for one accepted event and queue its result
        function void note(t_in_item it);
            t_out_item   res;
            logic [15:0] span;
            logic [15:0] offset;
            res  = '0;
            span = next_seq - base;
            res.status      = ST_OK;
            res.resend_kind = RESEND_NONE;
            case (it.command)
                CMD_SEND: begin
                    if (span < cwnd && span < win_cap) begin
                        res.send_granted = 1'b1;
                        res.send_seq     = next_seq;
                        if (span == '0) rto_ticks = '0;
                        next_seq = next_seq + 16'd1;
                    end else begin
                        res.status = ST_REFUSED;
                    end
                end
                CMD_ACK: begin
                    if (!it.ack_valid) begin
                        res.status = ST_BAD_ACK;
                    end else begin
                        offset = it.ack_seq - base;
                        if (offset < span) begin
                            // new cumulative ack
                            case (ph)
                                PH_SLOW: begin
                                    cwnd = grow(cwnd);
                                    if (cwnd >= ssthresh) ph = PH_AVOID;
                                end
                                PH_AVOID: begin
                                    if (avoid_acks != '1) avoid_acks++;
                                    if (avoid_acks >= cwnd) begin
                                        avoid_acks = '0;
                                        cwnd = grow(cwnd);
                                    end
                                end
                                default: begin
                                    cwnd       = floor_one(ssthresh);
                                    ph         = PH_AVOID;
                                    avoid_acks = '0;
                                end
                            endcase
                            res.released_count = 10'(offset + 16'd1);
                            base     = it.ack_seq + 16'd1;
                            dup_acks = '0;
                            if (base != next_seq) rto_ticks = '0;
                        end else begin
                            // stale or beyond next: duplicate
                            if (ph == PH_RECOV) cwnd = grow(cwnd);
                            if (dup_acks != '1) dup_acks++;
                            if (dup_acks == DUP_RTX) begin
                                if (ph != PH_RECOV) begin
                                    ph       = PH_RECOV;
                                    ssthresh = cwnd >> 1;
                                    cwnd     = floor_one(ssthresh + 10'd3);
                                end
                                if (span != '0) begin
                                    res.resend_kind  = RESEND_OLDEST;
                                    res.resend_from  = base;
                                    res.resend_count = 10'd1;
                                end
                            end
                        end
                    end
                end
                CMD_TICK: begin
                    if (span != '0) begin
                        if (rto_ticks != '1) rto_ticks++;
                        if (rto_ticks >= expiry_ticks) begin
                            dup_acks         = '0;
                            ssthresh         = cwnd >> 1;
                            cwnd             = 10'd1;
                            ph               = PH_SLOW;
                            res.resend_kind  = RESEND_ALL;
                            res.resend_from  = base;
                            res.resend_count = 10'(span);
                            rto_ticks        = '0;
                        end
                    end
                end
                default: ;
            endcase
            res.window_now    = cwnd;
            res.threshold_now = ssthresh;
            res.phase_now     = ph;
            res.base_now      = base;
            owed.insert(owed.size(), res);
        endfunction

        task report(string msg);
            mismatches++;
            $display("[%0t] mismatch: %s", $time, msg);
        endtask

        task same(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report($sformatf("result %0d %s got %0h want %0h", seen, name, got, want));
        endtask

        // compare one returned result with the oldest prediction
        task check(t_out_item got);
            t_out_item want;
            if (owed.size() == 0) begin
                report("result with nothing pending");
                return;
            end
            want = owed.pop_front();
            same("send_granted", got.send_granted, want.send_granted);
            same("send_seq", got.send_seq, want.send_seq);
            same("resend_kind", got.resend_kind, want.resend_kind);
            same("resend_from", got.resend_from, want.resend_from);
            same("resend_count", got.resend_count, want.resend_count);
            same("released_count", got.released_count, want.released_count);
            same("window_now", got.window_now, want.window_now);
            same("threshold_now", got.threshold_now, want.threshold_now);
            same("phase_now", got.phase_now, want.phase_now);
            same("base_now", got.base_now, want.base_now);
            same("status", got.status, want.status);
            seen++;
        endtask
    endclass

    logic                      i_clk = 1'b0;
    logic                      i_rst_n;
    logic                      i_in_valid;
    logic                      o_in_ready;
    t_in_item                  i_in_item;
    logic                      o_out_valid;
    logic                      i_out_ready = 1'b0;
    t_out_item                 o_out_item;
    logic                      i_cfg_we;
    logic [CFG_IDX_BITS-1:0]   i_cfg_index;
    logic [CFG_DATA_BITS-1:0]  i_cfg_wdata;

    sender_window_board sb;
    bit                 idle_on = 1'b1;
    int                 stall_cycles = 0;

    reno_window_sender_control_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // 20 ns clock
    always #10 i_clk = ~i_clk;

    // result side stalls at random
    always @(negedge i_clk) begin
        i_out_ready <= !(idle_on && $urandom_range(99) < 31);
    end

    // check every result transfer
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) sb.check(o_out_item);
    end

    // watchdog on cycles with no transfer on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic t_in_item mk(logic [1:0] cmd, logic [15:0] seq, logic ok);
        mk = '{command: cmd, ack_seq: seq, ack_valid: ok};
    endfunction

    // offer one event, wait for its transfer; called at a falling edge
    task automatic push(input t_in_item it);
        while (idle_on && $urandom_range(99) < 31) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note(it);
        @(negedge i_clk);
    endtask

    // hold off the sender until every owed result is back
    task automatic settle();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        sb.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // random traffic, mostly well-formed bursts built from the predicted state
    task automatic run_mixed(input int n_items);
        int          issued;
        int          pick;
        int          k;
        logic [15:0] span;
        logic [15:0] stale;
        issued = 0;
        while (issued < n_items) begin
            pick = $urandom_range(99);
            span = sb.in_flight();
            if (pick < 30) begin
                k = $urandom_range(1, 6);
                repeat (k) push(mk(CMD_SEND, 16'($urandom), 1'($urandom)));
                issued += k;
            end else if (pick < 55) begin
                if (span != '0)
                    push(mk(CMD_ACK, sb.base + 16'($urandom_range(0, span - 1)), 1'b1));
                else
                    push(mk(CMD_SEND, 16'($urandom), 1'($urandom)));
                issued++;
            end else if (pick < 68) begin
                // duplicate run: stale acks, some beyond next sequence
                k = $urandom_range(1, 8);
                stale = sb.base - 16'($urandom_range(1, 4));
                repeat (k) begin
                    if ($urandom_range(3) == 0)
                        push(mk(CMD_ACK, sb.next_seq + 16'($urandom_range(0, 200)), 1'b1));
                    else
                        push(mk(CMD_ACK, stale, 1'b1));
                end
                issued += k;
            end else if (pick < 83) begin
                k = $urandom_range(1, 12);
                repeat (k) push(mk(CMD_TICK, 16'($urandom), 1'($urandom)));
                issued += k;
            end else if (pick < 90) begin
                push(mk(CMD_ACK, 16'($urandom), 1'b0));
                issued++;
            end else begin
                push(mk(2'($urandom_range(0, 3)), 16'($urandom), 1'($urandom)));
                issued++;
            end
            if ($urandom_range(99) < 2) settle();
        end
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_item   = '0;
        i_cfg_we    = 1'b0;
        i_cfg_index = '0;
        i_cfg_wdata = '0;
        sb = new();
        sb.restart();
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: empty window, invalid ack, unused command
        push(mk(CMD_TICK, 16'h0000, 1'b1));
        push(mk(CMD_ACK, 16'h0000, 1'b1));
        push(mk(CMD_ACK, 16'hFFFF, 1'b0));
        push(mk(CMD_UNUSED, 16'hFFFF, 1'b1));
        // grant then refuse with a window of one
        push(mk(CMD_SEND, 16'h0000, 1'b0));
        push(mk(CMD_SEND, 16'hFFFF, 1'b1));
        push(mk(CMD_ACK, 16'h0000, 1'b1));
        // third duplicate with nothing outstanding: phase change, no resend
        repeat (3) push(mk(CMD_ACK, 16'h0000, 1'b1));
        repeat (5) push(mk(CMD_SEND, 16'h0000, 1'b0));
        // duplicates inside fast recovery grow the window
        repeat (2) push(mk(CMD_ACK, 16'hFFFF, 1'b1));
        push(mk(CMD_ACK, 16'h0002, 1'b1));
        // fast retransmit of the oldest packet, then exit with zero threshold
        repeat (3) push(mk(CMD_ACK, 16'h0000, 1'b1));
        push(mk(CMD_ACK, 16'h0004, 1'b1));
        run_mixed(20);

        // widest window, timer expires on every tick with data outstanding
        settle();
        write_reg(CFG_WIN_LIMIT, 32'd1023);
        write_reg(CFG_TIMEOUT, 32'd1);
        write_reg(CFG_INIT_THRESH, 32'd1023);
        run_mixed(20);

        // window cap of one, timer that never runs out
        settle();
        write_reg(CFG_WIN_LIMIT, 32'd1);
        write_reg(CFG_INIT_THRESH, 32'd0);
        write_reg(CFG_TIMEOUT, 32'hFFFF_FFFF);
        run_mixed(20);

        // mid-size cap, short timer
        settle();
        write_reg(CFG_WIN_LIMIT, 32'($urandom_range(2, 40)));
        write_reg(CFG_TIMEOUT, 32'($urandom_range(3, 30)));
        run_mixed(20);

        // no idling: clear the duplicate count with a new ack, then a
        // duplicate storm that drives the window to its ceiling
        settle();
        idle_on = 1'b0;
        push(mk(CMD_SEND, 16'($urandom), 1'($urandom)));
        push(mk(CMD_ACK, sb.next_seq - 16'd1, 1'b1));
        repeat (1030) push(mk(CMD_ACK, sb.base - 16'd1, 1'b1));
        settle();
        idle_on = 1'b1;
        run_mixed(20);

        settle();
        repeat (10) @(negedge i_clk);
        if (sb.mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== reno_window_sender_control_top.f =====
rtl/rwsc_pkg.sv
rtl/rwsc_cfg_regs.sv
rtl/rwsc_core.sv
rtl/reno_window_sender_control_top.sv
rtl/rwsc_checker.sv
tb/reno_window_sender_control_top_test.sv
